[src/tftp_rx_pkg.sv]
`timescale 1ns / 1ps

package tftp_rx_pkg;

    localparam logic [31:0] LOAD_BASE_RESET = 32'h3100_0000;
    localparam logic [15:0] DATA_OPCODE     = 16'd3;
    localparam logic        KIND_WRITE      = 1'b0;
    localparam logic        KIND_ACK        = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] write_address;
        logic [7:0]  write_data;
        logic [15:0] ack_block;
        logic [15:0] ack_port;
        logic        transfer_done;
        logic        last;
    } result_t;

endpackage

[src/tftp_data_receiver_top.sv]
`timescale 1ns / 1ps

// TFTP data receiver. The s_ channel carries the TFTP part of received UDP packets, one
// byte per word, with s_last_byte on the final byte and the server port in s_source_port.
// The m_ channel gives one result per word: a memory write (m_kind low) for each data
// byte of an accepted DATA packet, or an acknowledge (m_kind high) at the end of it.
// The final byte of an accepted packet that still carries data gives two words, the
// write first, then the acknowledge with m_last set.
// A result enters the result queue when its input word is taken. The block takes one
// input word every cycle while s_ready is high; a final byte that gives two results
// fills two queue entries, so the output side bounds the rate at one result per cycle.
// A three-entry result queue sits between the sides: input is taken while results wait,
// as long as room for two more results remains, so a stalled receiver stops the input
// once two results are waiting.
// The load_base register is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while the block is idle, which the block does not enforce. Reset empties
// the queue, sets load_base to 0x31000000, expects block one, and starts a new packet.
module tftp_data_receiver_top #(
    parameter int BLOCK_BYTES   = 512,
    parameter int POSITION_BITS = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_last_byte,
    input  logic [15:0] s_source_port,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [31:0] m_write_address,
    output logic [7:0]  m_write_data,
    output logic [15:0] m_ack_block,
    output logic [15:0] m_ack_port,
    output logic        m_transfer_done,
    output logic        m_last
);
    import tftp_rx_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX   = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_OP_LO = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_BLK_HI = POSITION_BITS'(2);
    localparam logic [POSITION_BITS-1:0] POS_BLK_LO = POSITION_BITS'(3);
    localparam logic [POSITION_BITS-1:0] POS_DATA  = POSITION_BITS'(4);
    localparam logic [31:0] BLOCK_STEP = 32'(BLOCK_BYTES);
    localparam logic [31:0] FULL_LIMIT = 32'(BLOCK_BYTES + 4);

    logic [31:0]              load_base_reg;
    logic [15:0]              expected_reg, expected_next;
    logic [31:0]              offset_reg, offset_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [7:0]               held_reg, held_next;
    logic                     is_data_reg, is_data_next;
    logic                     accepted_reg, accepted_next;

    result_t                  fifo_reg [3];
    logic [1:0]               count_reg, count_next;
    logic [1:0]               wr_ptr_reg, wr_ptr_next;
    logic [1:0]               rd_ptr_reg, rd_ptr_next;

    logic                     push, pop, sat;
    logic                     wr_hit, ack_hit, done;
    logic [POSITION_BITS-1:0] pos_after;
    logic [7:0]               held_after;
    logic                     is_data_after, accepted_after;
    logic [15:0]              word16;
    logic [1:0]               n_push;
    logic [1:0]               wr_ptr_inc;
    result_t                  write_rec, ack_rec, first_rec;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        return (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    assign pop     = m_valid && m_ready;
    assign s_ready = (count_reg <= 2'd1) || ((count_reg == 2'd2) && m_ready);
    assign push    = s_valid && s_ready;

    assign sat    = (pos_reg == POS_MAX);
    assign word16 = {held_reg, s_payload_byte};

    always_comb begin
        held_after     = held_reg;
        is_data_after  = is_data_reg;
        accepted_after = accepted_reg;
        pos_after      = pos_reg;
        if (!sat) begin
            pos_after = pos_reg + POSITION_BITS'(1);
            if (pos_reg == '0 || pos_reg == POS_BLK_HI) begin
                held_after = s_payload_byte;
            end else if (pos_reg == POS_OP_LO) begin
                is_data_after = (word16 == DATA_OPCODE);
            end else if (pos_reg == POS_BLK_LO) begin
                accepted_after = is_data_reg && (word16 == expected_reg);
            end
        end
    end

    assign wr_hit  = !sat && (pos_reg >= POS_DATA) && accepted_reg;
    assign ack_hit = s_last_byte && accepted_after;
    assign done    = (32'(pos_after) < FULL_LIMIT);
    assign n_push  = push ? (2'(wr_hit) + 2'(ack_hit)) : 2'd0;

    always_comb begin
        write_rec               = '0;
        write_rec.kind          = KIND_WRITE;
        write_rec.write_address = load_base_reg + offset_reg + (32'(pos_reg) - 32'd4);
        write_rec.write_data    = s_payload_byte;
        write_rec.last          = !s_last_byte;
        ack_rec                 = '0;
        ack_rec.kind            = KIND_ACK;
        ack_rec.ack_block       = expected_reg;
        ack_rec.ack_port        = s_source_port;
        ack_rec.transfer_done   = done;
        ack_rec.last            = 1'b1;
        first_rec               = wr_hit ? write_rec : ack_rec;
    end

    always_comb begin
        pos_next      = pos_reg;
        held_next     = held_reg;
        is_data_next  = is_data_reg;
        accepted_next = accepted_reg;
        expected_next = expected_reg;
        offset_next   = offset_reg;
        if (push) begin
            if (s_last_byte) begin
                pos_next      = '0;
                held_next     = '0;
                is_data_next  = 1'b0;
                accepted_next = 1'b0;
            end else begin
                pos_next      = pos_after;
                held_next     = held_after;
                is_data_next  = is_data_after;
                accepted_next = accepted_after;
            end
            if (ack_hit) begin
                if (done) begin
                    expected_next = 16'd1;
                    offset_next   = '0;
                end else begin
                    expected_next = expected_reg + 16'd1;
                    offset_next   = (expected_reg == 16'hFFFF) ? (32'd0 - BLOCK_STEP)
                                                               : (offset_reg + BLOCK_STEP);
                end
            end
        end
    end

    assign wr_ptr_inc  = ptr_inc(wr_ptr_reg);
    assign count_next  = count_reg - 2'(pop) + n_push;
    assign rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;

    always_comb begin
        unique case (n_push)
            2'd0:    wr_ptr_next = wr_ptr_reg;
            2'd1:    wr_ptr_next = wr_ptr_inc;
            default: wr_ptr_next = ptr_inc(wr_ptr_inc);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_base_reg <= LOAD_BASE_RESET;
            expected_reg  <= 16'd1;
            offset_reg    <= '0;
            pos_reg       <= '0;
            held_reg      <= '0;
            is_data_reg   <= 1'b0;
            accepted_reg  <= 1'b0;
            count_reg     <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                load_base_reg <= cfg_wr_data;
            end
            expected_reg <= expected_next;
            offset_reg   <= offset_next;
            pos_reg      <= pos_next;
            held_reg     <= held_next;
            is_data_reg  <= is_data_next;
            accepted_reg <= accepted_next;
            count_reg    <= count_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= first_rec;
        end
        if (n_push == 2'd2) begin
            fifo_reg[wr_ptr_inc] <= ack_rec;
        end
    end

    assign m_valid         = (count_reg != 2'd0);
    assign m_kind          = fifo_reg[rd_ptr_reg].kind;
    assign m_write_address = fifo_reg[rd_ptr_reg].write_address;
    assign m_write_data    = fifo_reg[rd_ptr_reg].write_data;
    assign m_ack_block     = fifo_reg[rd_ptr_reg].ack_block;
    assign m_ack_port      = fifo_reg[rd_ptr_reg].ack_port;
    assign m_transfer_done = fifo_reg[rd_ptr_reg].transfer_done;
    assign m_last          = fifo_reg[rd_ptr_reg].last;

    // The block offset register must always track the expected block number.
    a_offset_tracks_block: assert property (@(posedge aclk) disable iff (!aresetn)
        offset_reg == 32'((32'(expected_reg) - 32'd1) * BLOCK_STEP))
        else $error("block offset out of step with expected block");

    // The queue never takes more results than it has room for.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ((3'(count_reg) + 3'(n_push) - 3'(pop)) <= 3'd3))
        else $error("result queue overflow");

    // A word that does not end a packet always moves past the first position.
    a_position_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !s_last_byte) |=> (pos_reg != '0))
        else $error("byte position failed to advance");

endmodule
